/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define SFSG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slope field segment generator: assertion failed");

// cons must hold in the cycle after ante
`define SFSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slope field segment generator: assertion failed");

`endif

/* rtl/sfsg_pkg.sv */
// ----------------------------------------------------------------------------
// sfsg_pkg
// Types, constants and helpers for the slope field segment generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsg_pkg;

  localparam int MAX_DEGREE_DEF = 3;
  localparam int PIX_W     = 10;
  localparam int COEF_W    = 16;
  localparam int ACC_W     = 48;
  localparam int CRD_W     = 16;
  localparam int OUT_W     = 15;
  localparam int DIV_BITS  = 9;

  // Window of 600 pixels spans 100 plot units: q = (256p + 3) / 6.
  localparam int WIN_PIX   = 600;
  localparam int RECIP_3   = 43691;   // ceil(2^17 / 3)
  localparam int RECIP_SH  = 17;
  localparam logic signed [CRD_W-1:0] HALF_SPAN = 16'sd12800;
  localparam logic signed [17:0] ONE_Q8 = 18'sd256;

  localparam logic signed [63:0] SAT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT48_LO = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    SEG_VERT    = 2'd0,
    SEG_SHALLOW = 2'd1,
    SEG_STEEP   = 2'd2
  } seg_case_t;

  typedef enum logic [2:0] {
    CFG_F_COEF = 3'd0,
    CFG_G_COEF = 3'd1,
    CFG_F_DEG  = 3'd2,
    CFG_G_DEG  = 3'd3
  } cfg_idx_t;

  // One Horner step in flight
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] acc;
    logic signed [CRD_W-1:0] t;
  } poly_tok_t;

  // One quotient bit in flight
  typedef struct packed {
    logic                  vld;
    logic [ACC_W:0]        rem;
    logic [ACC_W-1:0]      den;
    logic [DIV_BITS-1:0]   quo;
  } div_tok_t;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [ACC_W-1:0] res;
    if (v > SAT48_HI) begin
      res = SAT48_HI[ACC_W-1:0];
    end else if (v < SAT48_LO) begin
      res = SAT48_LO[ACC_W-1:0];
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat15(input logic signed [17:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > 18'sd16383) begin
      res = 15'sd16383;
    end else if (v < -18'sd16384) begin
      res = -15'sd16384;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

  // Coefficient j of a packed word; out of range reads as zero
  function automatic logic signed [COEF_W-1:0] coef_pick(input logic [63:0] cw,
                                                          input int j);
    logic signed [COEF_W-1:0] res;
    if (j < 0 || j > 3) begin
      res = '0;
    end else begin
      res = cw[COEF_W*j +: COEF_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/sfsg_poly_cell.sv */
// ----------------------------------------------------------------------------
// sfsg_poly_cell
// One Horner step: acc = sat(floor(acc * t / 256)) then sat(acc + c * 256).
// Two register stages; the 48x16 product is split into two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsg_poly_cell
  import sfsg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [COEF_W-1:0] coef,
  input  wire poly_tok_t                tok_i,
  output poly_tok_t                     tok_o
);

  logic                    vld1_r;
  logic signed [40:0]      plo_r, plo_nxt;
  logic signed [39:0]      phi_r, phi_nxt;
  logic signed [CRD_W-1:0] t1_r;

  logic signed [63:0]      prod;
  logic signed [63:0]      shifted;
  logic signed [ACC_W-1:0] scaled;
  logic signed [ACC_W:0]   sum;
  poly_tok_t               tok_r, tok_nxt;

  assign plo_nxt = $signed({1'b0, tok_i.acc[23:0]}) * tok_i.t;
  assign phi_nxt = $signed(tok_i.acc[47:24]) * tok_i.t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= tok_i.vld;
    end
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    t1_r  <= tok_i.t;
  end

  always_comb begin
    prod    = (64'(phi_r) <<< 24) + 64'(plo_r);
    shifted = prod >>> 8;
    scaled  = sat48(shifted);
    sum     = {scaled[ACC_W-1], scaled} + {{25{coef[COEF_W-1]}}, coef, 8'b0};
    tok_nxt.vld = vld1_r;
    tok_nxt.acc = sat48(64'(sum));
    tok_nxt.t   = t1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.acc <= tok_nxt.acc;
    tok_r.t   <= tok_nxt.t;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

/* rtl/sfsg_div_cell.sv */
// ----------------------------------------------------------------------------
// sfsg_div_cell
// One restoring division step: retire one quotient bit and shift remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsg_div_cell
  import sfsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_tok_t tok_i,
  output div_tok_t      tok_o
);

  logic           ge;
  logic [ACC_W:0] diff;
  div_tok_t       tok_r, tok_nxt;

  always_comb begin
    ge   = tok_i.rem >= {1'b0, tok_i.den};
    diff = ge ? (tok_i.rem - {1'b0, tok_i.den}) : tok_i.rem;
    tok_nxt.vld = tok_i.vld;
    tok_nxt.rem = {diff[ACC_W-1:0], 1'b0};
    tok_nxt.den = tok_i.den;
    tok_nxt.quo = {tok_i.quo[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.rem <= tok_nxt.rem;
    tok_r.den <= tok_nxt.den;
    tok_r.quo <= tok_nxt.quo;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

/* rtl/slope_field_segment_generator.sv */
// Throughput: one pixel per cycle; busy stays low, start may be high every cycle.
// Latency is set by the Horner cell chain (two stages per cell) and the
// nine-cell quotient chain. Synchronous active-low reset clears all valid
// flags and the configuration registers; results are strobed, never stalled.
// ----------------------------------------------------------------------------
// slope_field_segment_generator
// Maps a pixel to plot coordinates, evaluates f(x) and g(y) through chains of
// Horner cells, and divides the smaller magnitude by the larger bit-serially.
// ----------------------------------------------------------------------------
`default_nettype none

module slope_field_segment_generator
  import sfsg_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [PIX_W-1:0]        in_pixel_x,
  input  wire logic [PIX_W-1:0]        in_pixel_y,
  output logic                         out_strobe,
  output logic signed [OUT_W-1:0]      out_end_a_x,
  output logic signed [OUT_W-1:0]      out_end_a_y,
  output logic signed [OUT_W-1:0]      out_end_b_x,
  output logic signed [OUT_W-1:0]      out_end_b_y,
  output logic [1:0]                   out_segment_case,
  output logic signed [ACC_W-1:0]      out_f_value,
  output logic signed [ACC_W-1:0]      out_g_value,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [63:0]             cfg_wdata
);

  `include "assert_macros.svh"

  localparam int NCELL = MAX_DEGREE + 1;
  localparam int LAT   = 2 * MAX_DEGREE + 15;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [ACC_W-1:0] fv;
    logic signed [ACC_W-1:0] gv;
    seg_case_t               kind;
    logic                    neg;
  } side_t;

  // configuration
  logic [63:0] f_coef_r, g_coef_r;
  logic [1:0]  f_deg_r, g_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_coef_r <= '0;
      g_coef_r <= '0;
      f_deg_r  <= '0;
      g_deg_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_F_COEF: f_coef_r <= cfg_wdata;
        CFG_G_COEF: g_coef_r <= cfg_wdata;
        CFG_F_DEG:  f_deg_r  <= cfg_wdata[1:0];
        CFG_G_DEG:  g_deg_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // pixel map, stage 1: clamp and form (256p + 3) / 2
  logic            vld0_r;
  logic [16:0]     ax_r, ay_r, ax_nxt, ay_nxt;
  logic [PIX_W-1:0] px_c, py_c;

  always_comb begin
    px_c   = (in_pixel_x > PIX_W'(WIN_PIX - 1)) ? PIX_W'(WIN_PIX - 1) : in_pixel_x;
    py_c   = (in_pixel_y > PIX_W'(WIN_PIX - 1)) ? PIX_W'(WIN_PIX - 1) : in_pixel_y;
    ax_nxt = 17'(({8'b0, px_c, 8'b0} + 26'd3) >> 1);
    ay_nxt = 17'(({8'b0, py_c, 8'b0} + 26'd3) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start;
    end
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
  end

  // pixel map, stage 2: divide by three through the reciprocal, then centre (y flipped)
  logic                    vld1_r;
  logic [33:0]             qx_prod, qy_prod;
  logic signed [CRD_W-1:0] x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    qx_prod = 34'(ax_r) * 34'(RECIP_3);
    qy_prod = 34'(ay_r) * 34'(RECIP_3);
    x_nxt   = $signed({1'b0, qx_prod[RECIP_SH +: CRD_W-1]}) - HALF_SPAN;
    y_nxt   = HALF_SPAN - $signed({1'b0, qy_prod[RECIP_SH +: CRD_W-1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld0_r;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  // Horner cell chains
  poly_tok_t f_tok [NCELL+1];
  poly_tok_t g_tok [NCELL+1];

  assign f_tok[0] = '{vld: vld1_r, acc: '0, t: x_r};
  assign g_tok[0] = '{vld: 1'b0,   acc: '0, t: y_r};

  for (genvar k = 0; k < NCELL; k++) begin : g_poly
    logic signed [COEF_W-1:0] f_c, g_c;
    int fd, gd;

    // lead with zero coefficients so every degree leaves the chain together
    always_comb begin
      fd  = (int'(f_deg_r) > MAX_DEGREE) ? MAX_DEGREE : int'(f_deg_r);
      gd  = (int'(g_deg_r) > MAX_DEGREE) ? MAX_DEGREE : int'(g_deg_r);
      f_c = coef_pick(f_coef_r, k - MAX_DEGREE + fd);
      g_c = coef_pick(g_coef_r, k - MAX_DEGREE + gd);
    end

    sfsg_poly_cell u_f_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .coef  (f_c),
      .tok_i (f_tok[k]),
      .tok_o (f_tok[k+1])
    );

    sfsg_poly_cell u_g_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .coef  (g_c),
      .tok_i (g_tok[k]),
      .tok_o (g_tok[k+1])
    );
  end

  // classify and set up the quotient
  logic signed [ACC_W-1:0] fv, gv;
  logic [ACC_W-1:0]        fa, ga, num, den;
  side_t                   side_nxt;
  div_tok_t                div_tok [DIV_BITS+1];
  div_tok_t                div0_r, div0_nxt;
  side_t                   side_r [DIV_BITS+1];

  always_comb begin
    fv = f_tok[NCELL].acc;
    gv = g_tok[NCELL].acc;
    fa = fv[ACC_W-1] ? ACC_W'(-fv) : fv;
    ga = gv[ACC_W-1] ? ACC_W'(-gv) : gv;
    side_nxt.x   = f_tok[NCELL].t;
    side_nxt.y   = g_tok[NCELL].t;
    side_nxt.fv  = fv;
    side_nxt.gv  = gv;
    side_nxt.neg = fv[ACC_W-1] ^ gv[ACC_W-1];
    priority if (gv == '0) begin
      side_nxt.kind = SEG_VERT;
      num = '0;
      den = ACC_W'(1);
    end else if (fa <= ga) begin
      side_nxt.kind = SEG_SHALLOW;
      num = fa;
      den = ga;
    end else begin
      side_nxt.kind = SEG_STEEP;
      num = ga;
      den = fa;
    end
    div0_nxt.vld = f_tok[NCELL].vld;
    div0_nxt.rem = {1'b0, num};
    div0_nxt.den = den;
    div0_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div0_r.vld <= 1'b0;
    end else begin
      div0_r.vld <= div0_nxt.vld;
    end
    div0_r.rem <= div0_nxt.rem;
    div0_r.den <= div0_nxt.den;
    div0_r.quo <= div0_nxt.quo;
    side_r[0]  <= side_nxt;
  end

  assign div_tok[0] = div0_r;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    sfsg_div_cell u_div_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (div_tok[k]),
      .tok_o (div_tok[k+1])
    );

    always_ff @(posedge clk) begin
      side_r[k+1] <= side_r[k];
    end
  end

  // round, place endpoints, saturate
  side_t                   sd;
  logic [ACC_W-1:0]        rem_f, dd;
  logic                    up;
  logic [9:0]              qr;
  logic signed [17:0]      mag, dlt, dx, dy, xw, yw;

  logic                    out_strobe_r;
  logic signed [OUT_W-1:0] ax_o_r, ay_o_r, bx_o_r, by_o_r;
  logic signed [OUT_W-1:0] ax_o_nxt, ay_o_nxt, bx_o_nxt, by_o_nxt;
  seg_case_t               kind_o_r;
  logic signed [ACC_W-1:0] fv_o_r, gv_o_r;

  always_comb begin
    sd    = side_r[DIV_BITS];
    rem_f = div_tok[DIV_BITS].rem[ACC_W:1];
    dd    = div_tok[DIV_BITS].den;
    up    = rem_f >= (dd - (dd >> 1));
    qr    = {1'b0, div_tok[DIV_BITS].quo} + {9'b0, up};
    mag   = $signed({8'b0, qr});
    dlt   = sd.neg ? -mag : mag;
    unique case (sd.kind)
      SEG_SHALLOW: begin
        dx = ONE_Q8;
        dy = dlt;
      end
      SEG_STEEP: begin
        dx = dlt;
        dy = ONE_Q8;
      end
      default: begin
        dx = '0;
        dy = ONE_Q8;
      end
    endcase
    xw       = 18'(sd.x);
    yw       = 18'(sd.y);
    ax_o_nxt = sat15(xw + dx);
    ay_o_nxt = sat15(yw + dy);
    bx_o_nxt = sat15(xw - dx);
    by_o_nxt = sat15(yw - dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_tok[DIV_BITS].vld;
    end
    ax_o_r   <= ax_o_nxt;
    ay_o_r   <= ay_o_nxt;
    bx_o_r   <= bx_o_nxt;
    by_o_r   <= by_o_nxt;
    kind_o_r <= sd.kind;
    fv_o_r   <= sd.fv;
    gv_o_r   <= sd.gv;
  end

  assign out_strobe       = out_strobe_r;
  assign out_end_a_x      = ax_o_r;
  assign out_end_a_y      = ay_o_r;
  assign out_end_b_x      = bx_o_r;
  assign out_end_b_y      = by_o_r;
  assign out_segment_case = kind_o_r;
  assign out_f_value      = fv_o_r;
  assign out_g_value      = gv_o_r;

  `SFSG_ASSERT_IMPL(a_latency, out_strobe, $past(start, LAT))
  `SFSG_ASSERT_IMPL(a_vert_zero_g, out_strobe && out_segment_case == SEG_VERT, out_g_value == '0)
  `SFSG_ASSERT_IMPL(a_vert_x, out_strobe && out_segment_case == SEG_VERT, out_end_a_x == out_end_b_x)
  `SFSG_ASSERT_IMPL(a_steep_y, out_strobe && out_segment_case == SEG_STEEP, 17'(out_end_a_y) - 17'(out_end_b_y) == 17'sd512)
  `SFSG_ASSERT_NEXT(a_strobe_chain, div_tok[DIV_BITS].vld, out_strobe)

endmodule

`default_nettype wire
